/* rtl/vhdl_char_lexer_top_macros.svh */
// Assertion macros shared by the lexer modules.
`ifndef VHDL_CHAR_LEXER_TOP_MACROS_SVH
`define VHDL_CHAR_LEXER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VCL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VCL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/vcl_pkg.sv */
package vcl_pkg;

  localparam int MAX_NAME_LEN = 64;
  localparam int MAX_LINE_LEN = 4096;

  localparam int KW_COUNT = 32;
  localparam int KW_MAX_CHARS = 12;

  localparam int COL_CNT_W = $clog2(MAX_LINE_LEN);
  localparam int LEN_CNT_W = $clog2(MAX_NAME_LEN + 2);

  localparam int CHAR_W = 8;
  localparam int LINE_W = 20;
  localparam int CLASS_W = 5;
  localparam int KW_IDX_W = 5;
  localparam int TOK_COL_W = 12;
  localparam int TOK_LEN_W = 7;
  localparam int ERR_W = 3;

  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 56;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [CLASS_W-1:0] CLS_IDENT   = 5'd0;
  localparam logic [CLASS_W-1:0] CLS_KEYWORD = 5'd1;
  localparam logic [CLASS_W-1:0] CLS_COLON   = 5'd2;
  localparam logic [CLASS_W-1:0] CLS_EQUAL   = 5'd3;
  localparam logic [CLASS_W-1:0] CLS_DOT     = 5'd4;
  localparam logic [CLASS_W-1:0] CLS_SEMI    = 5'd5;
  localparam logic [CLASS_W-1:0] CLS_COMMA   = 5'd6;
  localparam logic [CLASS_W-1:0] CLS_BAR     = 5'd7;
  localparam logic [CLASS_W-1:0] CLS_RPAREN  = 5'd8;
  localparam logic [CLASS_W-1:0] CLS_LPAREN  = 5'd9;
  localparam logic [CLASS_W-1:0] CLS_LBRACK  = 5'd10;
  localparam logic [CLASS_W-1:0] CLS_RBRACK  = 5'd11;
  localparam logic [CLASS_W-1:0] CLS_TICK    = 5'd12;
  localparam logic [CLASS_W-1:0] CLS_PLUS    = 5'd13;
  localparam logic [CLASS_W-1:0] CLS_MINUS   = 5'd14;
  localparam logic [CLASS_W-1:0] CLS_CARET   = 5'd15;
  localparam logic [CLASS_W-1:0] CLS_ERROR   = 5'd16;

  localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
  localparam logic [ERR_W-1:0] ERR_DIGIT      = 3'd1;
  localparam logic [ERR_W-1:0] ERR_UNKNOWN    = 3'd2;
  localparam logic [ERR_W-1:0] ERR_UNDERSCORE = 3'd3;
  localparam logic [ERR_W-1:0] ERR_TOO_LONG   = 3'd4;

  localparam logic [8*KW_MAX_CHARS-1:0] KW_STR [KW_COUNT] = '{
    "use", "alias", "architecture", "begin", "body", "constant", "downto",
    "if", "else", "elsif", "end", "entity", "generate", "in", "library",
    "out", "port", "of", "others", "package", "procedure", "process",
    "return", "signal", "then", "to", "variable", "default", "parameter",
    "and", "or", "xor"
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd5, 4'd12, 4'd5, 4'd4, 4'd8, 4'd6,
    4'd2, 4'd4, 4'd5, 4'd3, 4'd6, 4'd8, 4'd2, 4'd7,
    4'd3, 4'd4, 4'd2, 4'd6, 4'd7, 4'd9, 4'd7,
    4'd6, 4'd6, 4'd4, 4'd2, 4'd8, 4'd7, 4'd9,
    4'd3, 4'd2, 4'd3
  };

  typedef struct packed {
    logic [CLASS_W-1:0]   token_class;
    logic [KW_IDX_W-1:0]  keyword_index;
    logic [LINE_W-1:0]    token_line;
    logic [TOK_COL_W-1:0] token_column;
    logic [TOK_LEN_W-1:0] token_length;
    logic [ERR_W-1:0]     error_code;
    logic                 last_result;
  } tok_t;

  typedef struct packed {
    logic two;
    tok_t r0;
    tok_t r1;
  } q_ent_t;

  function automatic logic [7:0] kw_char(int k, logic [3:0] pos);
    int idx;
    idx = int'(KW_LEN[k]) - 1 - int'(pos);
    if (idx < 0) begin
      return 8'd0;
    end
    return KW_STR[k][8*idx +: 8];
  endfunction

  function automatic logic [KW_COUNT-1:0] feed_cand(logic [KW_COUNT-1:0] cand,
                                                    logic [LEN_CNT_W-1:0] pos,
                                                    logic [CHAR_W-1:0] c);
    logic [KW_COUNT-1:0] r;
    for (int k = 0; k < KW_COUNT; k++) begin
      r[k] = cand[k] && (int'(pos) < int'(KW_LEN[k])) && (kw_char(k, pos[3:0]) == c);
    end
    return r;
  endfunction

  function automatic tok_t flush_rec(logic [LEN_CNT_W-1:0] len,
                                     logic [KW_COUNT-1:0] cand,
                                     logic [COL_CNT_W-1:0] start,
                                     logic [LINE_W-1:0] line);
    tok_t t;
    t.token_class = CLS_IDENT;
    t.keyword_index = '0;
    t.token_line = line;
    t.token_column = TOK_COL_W'(start);
    t.token_length = TOK_LEN_W'(len);
    t.error_code = ERR_NONE;
    t.last_result = 1'b0;
    if (int'(len) > MAX_NAME_LEN) begin
      t.token_length = TOK_LEN_W'(MAX_NAME_LEN);
      t.error_code = ERR_TOO_LONG;
    end else begin
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
        if (cand[k] && (int'(len) == int'(KW_LEN[k]))) begin
          t.token_class = CLS_KEYWORD;
          t.keyword_index = KW_IDX_W'(k);
        end
      end
    end
    return t;
  endfunction

endpackage

/* rtl/vcl_front.sv */
module vcl_front
  import vcl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [LINE_W-1:0] line_number,
  input  logic              line_last,
  output logic              push,
  output q_ent_t            push_data
);

  logic                 in_name, in_name_next;
  logic [COL_CNT_W-1:0] start_col, start_col_next;
  logic [LEN_CNT_W-1:0] len_cnt, len_cnt_next;
  logic [KW_COUNT-1:0]  cand, cand_next;
  logic [COL_CNT_W-1:0] col_cnt, col_cnt_next;
  logic                 skip, skip_next;

  logic                 mid_in_name;
  logic [COL_CNT_W-1:0] mid_start;
  logic [LEN_CNT_W-1:0] mid_len;
  logic [KW_COUNT-1:0]  mid_cand;
  logic                 mid_skip;

  logic is_letter, is_digit, is_us, is_ws, is_nl, is_punct;
  logic [CLASS_W-1:0] pclass;
  logic flush1, emitc, flush2;
  tok_t rec_f1, rec_c, rec_f2, r0, r1;
  logic [1:0] n_res;

  always_comb begin
    is_letter = (char_code inside {["A":"Z"], ["a":"z"]});
    is_digit = (char_code inside {["0":"9"]});
    is_us = (char_code == "_");
    is_ws = (char_code inside {8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D});
    is_nl = (char_code == 8'h0A);
    is_punct = 1'b1;
    case (char_code)
      ":": pclass = CLS_COLON;
      "=": pclass = CLS_EQUAL;
      ".": pclass = CLS_DOT;
      ";": pclass = CLS_SEMI;
      ",": pclass = CLS_COMMA;
      "|": pclass = CLS_BAR;
      ")": pclass = CLS_RPAREN;
      "(": pclass = CLS_LPAREN;
      "[": pclass = CLS_LBRACK;
      "]": pclass = CLS_RBRACK;
      "'": pclass = CLS_TICK;
      "+": pclass = CLS_PLUS;
      "-": pclass = CLS_MINUS;
      "^": pclass = CLS_CARET;
      default: begin
        pclass = CLS_IDENT;
        is_punct = 1'b0;
      end
    endcase
  end

  always_comb begin
    flush1 = 1'b0;
    emitc = 1'b0;
    mid_in_name = in_name;
    mid_start = start_col;
    mid_len = len_cnt;
    mid_cand = cand;
    mid_skip = skip;
    rec_c.token_class = CLS_ERROR;
    rec_c.keyword_index = '0;
    rec_c.token_line = line_number;
    rec_c.token_column = TOK_COL_W'(col_cnt);
    rec_c.token_length = TOK_LEN_W'(1);
    rec_c.error_code = ERR_UNKNOWN;
    rec_c.last_result = 1'b0;
    if (skip) begin
      mid_skip = 1'b1;
    end else if (is_nl) begin
      flush1 = in_name;
      mid_in_name = 1'b0;
      mid_len = '0;
      mid_cand = '1;
      mid_skip = 1'b1;
    end else if (in_name && (is_letter || is_digit || is_us)) begin
      mid_cand = feed_cand(cand, len_cnt, char_code);
      if (int'(len_cnt) <= MAX_NAME_LEN) begin
        mid_len = len_cnt + LEN_CNT_W'(1);
      end
    end else begin
      flush1 = in_name;
      mid_in_name = 1'b0;
      mid_len = '0;
      mid_cand = '1;
      if (is_ws) begin
        emitc = 1'b0;
      end else if (is_digit) begin
        emitc = 1'b1;
        rec_c.error_code = ERR_DIGIT;
      end else if (is_punct) begin
        emitc = 1'b1;
        rec_c.token_class = pclass;
        rec_c.error_code = ERR_NONE;
      end else if (is_letter) begin
        mid_in_name = 1'b1;
        mid_start = col_cnt;
        mid_len = LEN_CNT_W'(1);
        mid_cand = feed_cand('1, '0, char_code);
      end else if (is_us) begin
        emitc = 1'b1;
        rec_c.error_code = ERR_UNDERSCORE;
      end else begin
        emitc = 1'b1;
      end
    end

    flush2 = line_last && mid_in_name;
    rec_f1 = flush_rec(len_cnt, cand, start_col, line_number);
    rec_f2 = flush_rec(mid_len, mid_cand, mid_start, line_number);

    n_res = 2'(flush1) + 2'(emitc) + 2'(flush2);
    r0 = flush1 ? rec_f1 : (emitc ? rec_c : rec_f2);
    r1 = (flush1 && emitc) ? rec_c : rec_f2;
    r0.last_result = (n_res != 2'd2);
    r1.last_result = 1'b1;
    push = accept && (n_res != 2'd0);
    push_data.two = (n_res == 2'd2);
    push_data.r0 = r0;
    push_data.r1 = r1;

    if (line_last) begin
      in_name_next = 1'b0;
      start_col_next = mid_start;
      len_cnt_next = '0;
      cand_next = '1;
      col_cnt_next = '0;
      skip_next = 1'b0;
    end else begin
      in_name_next = mid_in_name;
      start_col_next = mid_start;
      len_cnt_next = mid_len;
      cand_next = mid_cand;
      skip_next = mid_skip;
      if (col_cnt < COL_CNT_W'(MAX_LINE_LEN - 1)) begin
        col_cnt_next = col_cnt + COL_CNT_W'(1);
      end else begin
        col_cnt_next = col_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_name <= 1'b0;
      start_col <= '0;
      len_cnt <= '0;
      cand <= '1;
      col_cnt <= '0;
      skip <= 1'b0;
    end else if (accept) begin
      in_name <= in_name_next;
      start_col <= start_col_next;
      len_cnt <= len_cnt_next;
      cand <= cand_next;
      col_cnt <= col_cnt_next;
      skip <= skip_next;
    end
  end

endmodule

/* rtl/vcl_queue.sv */
module vcl_queue
  import vcl_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  q_ent_t push_data,
  output logic   full,
  input  logic   pop,
  output q_ent_t pop_data,
  output logic   empty
);

`include "vhdl_char_lexer_top_macros.svh"

  q_ent_t            mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full = (count == (QPTR_W+1)'(QDEPTH));
  assign empty = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  `VCL_ASSERT_SAME(a_no_overflow, push, !full || pop, "Queue written while full.")
  `VCL_ASSERT_SAME(a_no_underflow, pop, !empty, "Queue read while empty.")
  `VCL_ASSERT_SAME(a_count_bound, 1'b1, count <= (QPTR_W+1)'(QDEPTH), "Queue count too high.")

endmodule

/* rtl/vcl_back.sv */
module vcl_back
  import vcl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 empty,
  input  q_ent_t               pop_data,
  output logic                 pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tlast
);

`include "vhdl_char_lexer_top_macros.svh"

  logic   valid;
  logic   phase;
  q_ent_t ent;
  tok_t   cur;
  logic   take;
  logic   done;

  assign take = valid && m_tready;
  assign done = !valid || (take && (phase || !ent.two));
  assign pop = done && !empty;
  assign cur = phase ? ent.r1 : ent.r0;

  assign m_tvalid = valid;
  assign m_tlast = cur.last_result;
  assign m_tdata = {{(M_TDATA_W - 52){1'b0}}, cur.error_code, cur.token_length,
                    cur.token_column, cur.token_line, cur.keyword_index,
                    cur.token_class};

  always_ff @(posedge clk) begin
    if (pop) begin
      ent <= pop_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      phase <= 1'b0;
    end else if (done) begin
      valid <= !empty;
      phase <= 1'b0;
    end else if (take) begin
      phase <= 1'b1;
    end
  end

  `VCL_ASSERT_SAME(a_phase_two, phase, valid && ent.two, "Second request without a pair.")
  `VCL_ASSERT_NEXT(a_pair_second, take && !phase && ent.two, valid && phase,
                   "Second request of a pair was dropped.")
  `VCL_ASSERT_NEXT(a_pop_loads, pop, valid && !phase, "Entry taken from the queue was lost.")

endmodule

/* rtl/vhdl_char_lexer_top.sv */
// Path: an accepted character's tokens are written into the queue, then loaded into the
// output register before they are presented on m_tdata.
// Throughput: one character per cycle while the queue is not full; a character with two
// tokens is sent as two transfers; a four-entry queue absorbs bursts and downstream stalls.
// Reset: synchronous, active high; clears the scanner state, the queue and the output
// register, and the block accepts characters in the cycle after reset is released.
module vhdl_char_lexer_top
  import vcl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // char_code[7:0], line_number[27:8], zero pad
  input  logic                 s_tlast,  // line_last
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,  // token_class, keyword_index, token_line,
                                         // token_column, token_length, error_code, pad
  output logic                 m_tlast   // last_result
);

  logic   accept;
  logic   push;
  q_ent_t push_data;
  logic   full;
  logic   pop;
  q_ent_t pop_data;
  logic   empty;
  logic   unused_pad;

  assign s_tready = !full;
  assign accept = s_tvalid && s_tready;
  assign unused_pad = ^s_tdata[S_TDATA_W-1:CHAR_W+LINE_W];

  vcl_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .char_code   (s_tdata[CHAR_W-1:0]),
    .line_number (s_tdata[CHAR_W+LINE_W-1:CHAR_W]),
    .line_last   (s_tlast),
    .push        (push),
    .push_data   (push_data)
  );

  vcl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  vcl_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .pop_data (pop_data),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
